### sv/kwm_pkg.sv
// Shared types and constants for the k-way sorted merge.
// No dependencies; compiled first.
package kwm_pkg;

    // Widest lane index that any configuration of the block may need.
    localparam int MAX_LANES  = 64;
    localparam int MAX_LANE_W = 6;

    // Outcome of the minimum search over the head slots.
    typedef struct packed {
        logic                  found;
        logic [MAX_LANE_W-1:0] lane;
    } kwm_sel_t;

endpackage

### sv/kwm_if.sv
// Valid/ready channel interfaces for the merge: input elements and merged results.
// Self-contained; compiled after kwm_pkg.
interface kwm_in_if #(
    parameter int LANE_W      = 3,
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [LANE_W-1:0]             lane;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          exhausted;

    modport source (output valid, lane, value, exhausted, input ready);
    modport sink   (input valid, lane, value, exhausted, output ready);
endinterface

interface kwm_out_if #(
    parameter int LANE_W      = 3,
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] merged_value;
    logic [LANE_W-1:0]             fetch_lane;
    logic                          done_res;

    modport source (output valid, merged_value, fetch_lane, done_res, input ready);
    modport sink   (input valid, merged_value, fetch_lane, done_res, output ready);
endinterface

### sv/kwm_min_tree.sv
// Combinational minimum search over the per-lane head slots, ties to the lowest lane.
// Depends on kwm_pkg for the selection result type.
module kwm_min_tree #(
    parameter int LANES       = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic [LANES-1:0]              full,
    input  logic signed [VALUE_WIDTH-1:0] heads [LANES],
    output kwm_pkg::kwm_sel_t             sel,
    output logic signed [VALUE_WIDTH-1:0] min_value
);
    import kwm_pkg::*;

    localparam int LANE_W = $clog2(LANES);
    localparam int LEAVES = 1 << LANE_W;

    // Heap-ordered nodes: the root is node 1, leaves start at LEAVES.
    logic                          node_valid [2*LEAVES];
    logic signed [VALUE_WIDTH-1:0] node_value [2*LEAVES];
    logic [LANE_W-1:0]             node_lane  [2*LEAVES];

    // Node zero is never part of the tree; tie it off.
    assign node_valid[0] = 1'b0;
    assign node_value[0] = '0;
    assign node_lane[0]  = '0;

    // Leaves: one per lane, padding leaves never win.
    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < LANES) begin : g_used
            assign node_valid[LEAVES+k] = full[k];
            assign node_value[LEAVES+k] = heads[k];
        end
        else begin : g_pad
            assign node_valid[LEAVES+k] = 1'b0;
            assign node_value[LEAVES+k] = '0;
        end
        assign node_lane[LEAVES+k] = LANE_W'(k);
    end

    // Inner nodes: the left child holds the lower lanes, so it keeps ties.
    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        logic take_right;
        assign take_right = node_valid[2*n+1] &&
                            (!node_valid[2*n] || (node_value[2*n+1] < node_value[2*n]));
        assign node_valid[n] = node_valid[2*n] || node_valid[2*n+1];
        assign node_value[n] = take_right ? node_value[2*n+1] : node_value[2*n];
        assign node_lane[n]  = take_right ? node_lane[2*n+1]  : node_lane[2*n];
    end

    assign sel.found = node_valid[1];
    assign sel.lane  = MAX_LANE_W'(node_lane[1]);
    assign min_value = node_value[1];

endmodule

### sv/k_way_sorted_merge.sv
// Path: an accepted beat is held in the input register until the result register can take a beat;
// its result beat, if any, is then registered in the result register and presented from there.
// Throughput: one input beat per cycle while results are taken, set by the combinational
// head update and minimum-select tree between the input and result registers.
// Reset: every lane awaited, no heads held, nothing finished, lane count eight (clamped
// to LANES); the head values themselves are not cleared and need no clearing pass.
module k_way_sorted_merge #(
    parameter int LANES       = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [$clog2(LANES+1)-1:0]   cfg_data,
    kwm_in_if.sink                       items,
    kwm_out_if.source                    results
);
    import kwm_pkg::*;

    localparam int LANE_W      = $clog2(LANES);
    localparam int CNT_W       = $clog2(LANES + 1);
    localparam int RESET_LANES = (LANES < 8) ? LANES : 8;

    // Lane count, stored already clamped to 1 .. LANES.
    logic [CNT_W-1:0] lanes_reg;

    // Input register.
    logic                          stage_valid_reg;
    logic [LANE_W-1:0]             stage_lane_reg;
    logic signed [VALUE_WIDTH-1:0] stage_value_reg;
    logic                          stage_exh_reg;

    // Per-lane head slots and flags.
    logic signed [VALUE_WIDTH-1:0] head_value_reg [LANES];
    logic [LANES-1:0]              full_reg, full_next;
    logic [LANES-1:0]              fin_reg, fin_next;
    logic [LANES-1:0]              await_reg, await_next;

    // Result register.
    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_WIDTH-1:0] out_value_reg;
    logic [LANE_W-1:0]             out_lane_reg;
    logic                          out_done_reg;

    // Evaluation signals.
    logic                          out_free, stage_go, accept;
    logic                          lane_ok, take, all_ready, fire;
    logic [LANES-1:0]              in_use, full_upd, fin_upd;
    logic signed [VALUE_WIDTH-1:0] heads_upd [LANES];
    kwm_sel_t                      sel;
    logic signed [VALUE_WIDTH-1:0] min_value;
    logic [LANE_W-1:0]             best;

    // Handshake: the input register drains whenever the result register can take a beat.
    assign out_free    = !out_valid_reg || results.ready;
    assign stage_go    = stage_valid_reg && out_free;
    assign items.ready = !stage_valid_reg || stage_go;
    assign accept      = items.valid && items.ready;

    // Apply the staged beat to the head slots, as seen by the selection this cycle.
    always_comb
    begin
        lane_ok = CNT_W'(stage_lane_reg) < lanes_reg;
        take    = stage_go && lane_ok && await_reg[stage_lane_reg];
        for (int i = 0; i < LANES; i++)
        begin
            in_use[i]    = i < int'(lanes_reg);
            full_upd[i]  = full_reg[i];
            fin_upd[i]   = fin_reg[i];
            heads_upd[i] = head_value_reg[i];
            if (take && (stage_lane_reg == LANE_W'(i)))
            begin
                if (stage_exh_reg)
                begin
                    fin_upd[i] = 1'b1;
                end
                else
                begin
                    full_upd[i]  = 1'b1;
                    heads_upd[i] = stage_value_reg;
                end
            end
        end
        all_ready = &(~in_use | full_upd | fin_upd);
        fire      = take && all_ready;
    end

    kwm_min_tree #(
        .LANES       (LANES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_min_tree (
        .full      (full_upd & in_use),
        .heads     (heads_upd),
        .sel       (sel),
        .min_value (min_value)
    );

    assign best = sel.lane[LANE_W-1:0];

    // Flag updates: emit the winner and await its lane, or refill everything when done.
    always_comb
    begin
        full_next  = full_upd;
        fin_next   = fin_upd;
        await_next = await_reg;
        if (take)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (stage_lane_reg == LANE_W'(i))
                begin
                    await_next[i] = 1'b0;
                end
            end
        end
        if (fire)
        begin
            if (sel.found)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (best == LANE_W'(i))
                    begin
                        full_next[i]  = 1'b0;
                        await_next[i] = 1'b1;
                    end
                end
            end
            else
            begin
                full_next  = '0;
                fin_next   = '0;
                await_next = '1;
            end
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg       <= CNT_W'(RESET_LANES);
            stage_valid_reg <= 1'b0;
            full_reg        <= '0;
            fin_reg         <= '0;
            await_reg       <= '1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_data == '0)
                begin
                    lanes_reg <= CNT_W'(1);
                end
                else if (int'(cfg_data) > LANES)
                begin
                    lanes_reg <= CNT_W'(LANES);
                end
                else
                begin
                    lanes_reg <= cfg_data;
                end
            end
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (stage_go)
            begin
                stage_valid_reg <= 1'b0;
            end
            full_reg      <= full_next;
            fin_reg       <= fin_next;
            await_reg     <= await_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input beat, head slots and result beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_lane_reg  <= items.lane;
            stage_value_reg <= items.value;
            stage_exh_reg   <= items.exhausted;
        end
        if (take && !stage_exh_reg)
        begin
            head_value_reg[stage_lane_reg] <= stage_value_reg;
        end
        if (fire)
        begin
            if (sel.found)
            begin
                out_value_reg <= min_value;
                out_lane_reg  <= best;
                out_done_reg  <= 1'b0;
            end
            else
            begin
                out_value_reg <= '0;
                out_lane_reg  <= '0;
                out_done_reg  <= 1'b1;
            end
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.merged_value = out_value_reg;
    assign results.fetch_lane   = out_lane_reg;
    assign results.done_res     = out_done_reg;

    // A lane never holds a head and is finished at once.
    assert property (@(posedge clk) disable iff (!rst_n) (full_reg & fin_reg) == '0)
        else $error("lane both holds a head and is finished");

    // An awaited lane holds neither a head nor a finished mark.
    assert property (@(posedge clk) disable iff (!rst_n) (await_reg & (full_reg | fin_reg)) == '0)
        else $error("awaited lane already holds a head or is finished");

    // A done beat carries a zero value and lane zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> (out_value_reg == '0) && (out_lane_reg == '0))
        else $error("done beat with non-zero payload");

    // A staged beat held back by a stalled result stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !out_free |=> stage_valid_reg && $stable(stage_lane_reg))
        else $error("staged beat lost while the result side stalled");

    // The lane count always stays within 1 .. LANES.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lanes_reg != '0) && (int'(lanes_reg) <= LANES))
        else $error("lane count out of range");

endmodule

### tb/sv/tb_k_way_sorted_merge.sv
// Self-checking testbench for the k-way sorted merge: beats are predicted from a
// behavioural model of the head slots and compared field by field with the result channel.
// Depends on kwm_pkg, kwm_if.sv and k_way_sorted_merge.sv.
module tb_k_way_sorted_merge;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES         = 8;
    localparam int VW            = 32;
    localparam int LW            = 3;
    localparam int CW            = $clog2(LANES + 1);
    localparam int SETTLE_CYCLES = 4;
    localparam int RX_HOLD       = 100;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 125;

    typedef struct packed {
        logic [LW-1:0]        lane;
        logic signed [VW-1:0] value;
        logic                 exhausted;
    } elem_t;

    typedef struct packed {
        logic signed [VW-1:0] merged_value;
        logic [LW-1:0]        fetch_lane;
        logic                 done_res;
    } merged_t;

    typedef struct packed {
        logic [LANES-1:0][VW-1:0] head;
        logic [LANES-1:0]         full;
        logic [LANES-1:0]         finished;
        logic [LANES-1:0]         awaited;
    } merge_state_t;

    typedef enum int {STEP_IGNORED, STEP_HELD, STEP_EMITTED} step_outcome_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_we       = 1'b0;
    logic [CW-1:0]    cfg_data     = '0;
    logic             in_valid     = 1'b0;
    elem_t            in_beat      = '0;
    logic             out_ready    = 1'b0;

    // Register copy, live merge state and the plan state used to shape stimulus.
    logic [CW-1:0]    lane_cnt_reg = CW'(LANES);
    merge_state_t     pred_st;
    merge_state_t     plan_st;
    logic signed [VW-1:0] lane_last [LANES];
    logic [LANES-1:0] lane_started = '0;

    elem_t            pending_q [$];
    merged_t          merged_q [$];
    int               beats_queued   = 0;
    int               beats_taken    = 0;
    int               fail_count     = 0;
    int               quiet_cycles   = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    bit               rx_hold_armed  = 1'b0;

    kwm_in_if  #(.LANE_W(LW), .VALUE_WIDTH(VW)) items_if ();
    kwm_out_if #(.LANE_W(LW), .VALUE_WIDTH(VW)) results_if ();

    assign items_if.valid     = in_valid;
    assign items_if.lane      = in_beat.lane;
    assign items_if.value     = in_beat.value;
    assign items_if.exhausted = in_beat.exhausted;
    assign results_if.ready   = out_ready;

    k_way_sorted_merge #(
        .LANES       (LANES),
        .VALUE_WIDTH (VW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .items    (items_if),
        .results  (results_if)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic merge_state_t fresh_state();
        merge_state_t st;
        st          = '0;
        st.awaited  = '1;
        return st;
    endfunction

    // A lane count of zero behaves as one lane; anything above LANES as LANES.
    function automatic int lanes_active(input logic [CW-1:0] c);
        if (c == 0)
            return 1;
        if (int'(c) > LANES)
            return LANES;
        return int'(c);
    endfunction

    // One element into the head slots; returns whether it was ignored, held or produced a beat.
    function automatic step_outcome_t merge_step(inout merge_state_t st,
                                                 input logic [CW-1:0] c,
                                                 input elem_t e,
                                                 output merged_t r);
        int n;
        int best;
        bit found;
        n = lanes_active(c);
        r = '0;
        if (int'(e.lane) >= n || !st.awaited[e.lane])
            return STEP_IGNORED;
        st.awaited[e.lane] = 1'b0;
        if (e.exhausted)
            st.finished[e.lane] = 1'b1;
        else
        begin
            st.head[e.lane] = e.value;
            st.full[e.lane] = 1'b1;
        end
        for (int i = 0; i < n; i++)
            if (!st.full[i] && !st.finished[i])
                return STEP_HELD;
        // Minimum over the held heads; the strict compare keeps the lowest lane on a tie.
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < n; i++)
            if (st.full[i] && (!found || $signed(st.head[i]) < $signed(st.head[best])))
            begin
                best  = i;
                found = 1'b1;
            end
        if (!found)
        begin
            r.done_res = 1'b1;
            st = fresh_state();
            return STEP_EMITTED;
        end
        r.merged_value   = st.head[best];
        r.fetch_lane     = LW'(best);
        st.full[best]    = 1'b0;
        st.awaited[best] = 1'b1;
        return STEP_EMITTED;
    endfunction

    function automatic logic [LANES-1:0] awaited_lanes(input merge_state_t st,
                                                       input logic [CW-1:0] c);
        logic [LANES-1:0] m;
        int n;
        n = lanes_active(c);
        m = '0;
        for (int i = 0; i < n; i++)
            m[i] = st.awaited[i];
        return m;
    endfunction

    function automatic int pick_awaited(input logic [LANES-1:0] m);
        int l;
        l = $urandom_range(LANES - 1);
        while (!m[l])
            l = $urandom_range(LANES - 1);
        return l;
    endfunction

    function automatic elem_t elem(input int lane, input logic signed [VW-1:0] value,
                                   input logic exh);
        elem_t e;
        e.lane      = LW'(lane);
        e.value     = value;
        e.exhausted = exh;
        return e;
    endfunction

    // Queue a beat and advance the plan state so that later beats can follow the merge.
    task automatic push_item(input elem_t e, output step_outcome_t oc, output merged_t r);
        oc = merge_step(plan_st, lane_cnt_reg, e, r);
        pending_q.push_back(e);
        beats_queued++;
        if (oc != STEP_IGNORED && !e.exhausted)
        begin
            lane_last[e.lane]    = e.value;
            lane_started[e.lane] = 1'b1;
        end
        if (oc == STEP_EMITTED && r.done_res)
            lane_started = '0;
    endtask

    // Exhaust whichever lanes are awaited until the merge reports done.
    task automatic finish_merge();
        step_outcome_t oc = STEP_IGNORED;
        merged_t r = '0;
        logic [LANES-1:0] m;
        while (!(oc == STEP_EMITTED && r.done_res))
        begin
            m = awaited_lanes(plan_st, lane_cnt_reg);
            if (m == 0)
                break;
            push_item(elem(pick_awaited(m), $urandom(), 1'b1), oc, r);
        end
    endtask

    // Hold the sender back until every queued beat is taken and every result has come.
    task automatic wait_drained();
        while (beats_taken != beats_queued || merged_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CW-1:0] v);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_data     <= v;
        lane_cnt_reg  = v;
        @(posedge clk);
        cfg_we       <= 1'b0;
    endtask

    // Input driver: predicts on each accepted beat and offers the next pending one.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        merged_t       r;
        step_outcome_t oc;
        logic          take;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            take = in_valid && items_if.ready;
            if (take)
            begin
                oc = merge_step(pred_st, lane_cnt_reg, in_beat, r);
                if (oc == STEP_EMITTED)
                    merged_q.push_back(r);
                beats_taken++;
            end
            if (!in_valid || take)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_beat  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted beat and drives ready, with an optional long hold.
    always @(posedge clk or negedge rst_n)
    begin : collect_results
        merged_t want;
        bit      rx_hold_taken;
        int      rx_hold_left;
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            rx_hold_taken  = 1'b0;
            rx_hold_left   = 0;
        end
        else
        begin
            if (results_if.valid && out_ready)
            begin
                if (merged_q.size() == 0)
                begin
                    $error("result beat with nothing expected: merged_value %0d, fetch_lane %0d",
                           results_if.merged_value, results_if.fetch_lane);
                    fail_count++;
                end
                else
                begin
                    want = merged_q.pop_front();
                    if (results_if.merged_value !== want.merged_value)
                    begin
                        $error("merged_value: expected %0d, got %0d",
                               want.merged_value, results_if.merged_value);
                        fail_count++;
                    end
                    if (results_if.fetch_lane !== want.fetch_lane)
                    begin
                        $error("fetch_lane: expected %0d, got %0d",
                               want.fetch_lane, results_if.fetch_lane);
                        fail_count++;
                    end
                    if (results_if.done_res !== want.done_res)
                    begin
                        $error("done_res: expected %0d, got %0d",
                               want.done_res, results_if.done_res);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_armed && !rx_hold_taken)
            begin
                rx_hold_taken = 1'b1;
                rx_hold_left  = RX_HOLD;
            end
            else if (!rx_hold_armed)
                rx_hold_taken = 1'b0;
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && items_if.ready) || (results_if.valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus: directed cases first, then random phases over several lane counts.
    initial
    begin
        step_outcome_t    oc;
        merged_t          r;
        elem_t            e;
        logic [LANES-1:0] m;
        logic signed [VW-1:0] v;
        longint           nxt;
        int               made;
        int               roll;
        int               l;
        logic [CW-1:0]    cfg_plan [$];

        pred_st = fresh_state();
        plan_st = fresh_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Full fill at the reset lane count: both extremes, zero, minus one, a tie, an
        // exhausted lane; then a beat for a lane that already holds a head.
        push_item(elem(7, 1, 1'b0), oc, r);
        push_item(elem(6, $urandom(), 1'b1), oc, r);
        push_item(elem(5, 5, 1'b0), oc, r);
        push_item(elem(4, 5, 1'b0), oc, r);
        push_item(elem(3, -1, 1'b0), oc, r);
        push_item(elem(2, 0, 1'b0), oc, r);
        push_item(elem(1, 32'sh8000_0000, 1'b0), oc, r);
        push_item(elem(0, 32'sh7FFF_FFFF, 1'b0), oc, r);
        push_item(elem(0, 3, 1'b0), oc, r);
        finish_merge();
        wait_drained();

        // Lane outside the set in use, then the lane count changed while a merge is open.
        write_cfg(3);
        push_item(elem(5, 9, 1'b0), oc, r);
        push_item(elem(0, 10, 1'b0), oc, r);
        wait_drained();
        write_cfg(2);
        push_item(elem(2, 11, 1'b0), oc, r);
        push_item(elem(1, 20, 1'b0), oc, r);
        wait_drained();

        // A count of zero acts as a single lane, so exhausting lane 0 completes the merge.
        write_cfg(0);
        push_item(elem(0, $urandom(), 1'b1), oc, r);
        push_item(elem(1, 4, 1'b0), oc, r);
        push_item(elem(0, -7, 1'b0), oc, r);
        push_item(elem(0, $urandom(), 1'b1), oc, r);
        wait_drained();

        cfg_plan = '{15, 1, 5, 8, 0, 2, 9, 4};
        for (int ph = 0; ph < cfg_plan.size(); ph++)
        begin
            finish_merge();
            wait_drained();
            write_cfg(cfg_plan[ph]);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            // In every fourth phase the receiver holds off while the queue fills, so the block backs up.
            rx_hold_armed = (ph % 4 == 0);
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                m    = awaited_lanes(plan_st, lane_cnt_reg);
                roll = $urandom_range(99);
                if (roll < 12 || m == 0)
                    e = elem($urandom_range(LANES - 1), $urandom(), $urandom_range(1));
                else
                begin
                    l = pick_awaited(m);
                    if ($urandom_range(7) == 0)
                        e = elem(l, $urandom(), 1'b1);
                    else if (roll < 17)
                        e = elem(l, $urandom(), 1'b0);
                    else
                    begin
                        // Ascending stream per lane, saturating at the top of the range.
                        if (!lane_started[l])
                            case ($urandom_range(3))
                                0:       v = $urandom();
                                1:       v = int'($urandom_range(40)) - 20;
                                2:       v = 32'sh8000_0000 + int'($urandom_range(50));
                                default: v = 32'sh7FFF_FFFF - int'($urandom_range(50));
                            endcase
                        else
                        begin
                            case ($urandom_range(3))
                                0:       nxt = longint'(lane_last[l]);
                                1:       nxt = longint'(lane_last[l]) + $urandom_range(3);
                                2:       nxt = longint'(lane_last[l]) + $urandom_range(1000);
                                default: nxt = longint'(lane_last[l])
                                               + $urandom_range(32'h0FFF_FFFF);
                            endcase
                            if (nxt > longint'(32'sh7FFF_FFFF))
                                nxt = longint'(32'sh7FFF_FFFF);
                            v = VW'(nxt);
                        end
                        e = elem(l, v, 1'b0);
                    end
                end
                push_item(e, oc, r);
                if (oc != STEP_IGNORED)
                    made++;
            end
            wait_drained();
            rx_hold_armed = 1'b0;
        end

        wait_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
sv/kwm_pkg.sv
sv/kwm_if.sv
sv/kwm_min_tree.sv
sv/k_way_sorted_merge.sv
tb/sv/tb_k_way_sorted_merge.sv
